// ----- src/integer_to_ascii_radix_core_defines.svh -----
// ---------------------------------------------------------------------------
// Assertion macros for the integer to ASCII radix core
// Concurrent check wrappers that can be compiled out with NO_ASSERTIONS.
// ---------------------------------------------------------------------------
`ifndef INTEGER_TO_ASCII_RADIX_CORE_DEFINES_SVH
`define INTEGER_TO_ASCII_RADIX_CORE_DEFINES_SVH

`ifndef NO_ASSERTIONS
`define ITOA_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("itoa check failed");
`define ITOA_NEVER(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(prop)) \
    else $error("itoa forbidden condition seen");
`else
`define ITOA_ASSERT(lbl, clk, rst_n, prop)
`define ITOA_NEVER(lbl, clk, rst_n, prop)
`endif

`endif

// ----- src/itoa_pkg.sv -----
// ---------------------------------------------------------------------------
// itoa_pkg
// Widths, constants, payload types and helpers shared by the itoa core.
// ---------------------------------------------------------------------------
package itoa_pkg;

  localparam int VALUE_BITS = 32;
  localparam int RADIX_BITS = 6;
  localparam int CHAR_BITS  = 7;
  localparam int DIGIT_BITS = RADIX_BITS;

  // Quotient bits resolved per divider cycle.
  localparam int STEP_BITS  = 8;
  localparam int DIV_STEPS  = VALUE_BITS / STEP_BITS;
  localparam int STEP_W     = (DIV_STEPS > 1) ? $clog2(DIV_STEPS) : 1;

  localparam int MAX_DIGITS = VALUE_BITS;
  localparam int DIGIT_AW   = $clog2(MAX_DIGITS);
  localparam int CNT_BITS   = $clog2(MAX_DIGITS + 1);

  localparam int WORK_DEPTH_DEF = 2;
  localparam int RES_DEPTH_DEF  = 2;

  localparam logic [CHAR_BITS-1:0]  ASCII_ZERO   = 7'h30;
  localparam logic [CHAR_BITS-1:0]  ASCII_MINUS  = 7'h2D;
  localparam logic [CHAR_BITS-1:0]  LETTER_GAP   = 7'd39;
  localparam logic [DIGIT_BITS-1:0] LAST_DECIMAL = 6'd9;
  localparam logic [RADIX_BITS-1:0] RADIX_MIN    = 6'd2;
  localparam logic [RADIX_BITS-1:0] RADIX_MAX    = 6'd36;

  typedef struct packed {
    logic signed [VALUE_BITS-1:0] value;
    logic [RADIX_BITS-1:0]        radix;
  } in_item_t;

  typedef struct packed {
    logic [CHAR_BITS-1:0] char_code;
    logic                 last_char;
  } out_item_t;

  // Classified work item handed from the front to the back.
  typedef struct packed {
    logic                  negative;
    logic [VALUE_BITS-1:0] mag;
    logic [RADIX_BITS-1:0] radix;
  } work_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_SIGN,
    ST_EMIT
  } back_state_e;

  function automatic logic [CHAR_BITS-1:0] digit_to_char(logic [DIGIT_BITS-1:0] d);
    logic [CHAR_BITS-1:0] c;
    c = CHAR_BITS'(d) + ASCII_ZERO;
    if (d > LAST_DECIMAL) begin
      c = c + LETTER_GAP;
    end
    return c;
  endfunction

endpackage

// ----- src/itoa_fifo.sv -----
// ---------------------------------------------------------------------------
// itoa_fifo
// Small synchronous first-word-fall-through queue with a fill level output.
// ---------------------------------------------------------------------------
module itoa_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         push_i,
  input  logic [WIDTH-1:0]             wr_data_i,
  input  logic                         pop_i,
  output logic [WIDTH-1:0]             rd_data_o,
  output logic                         full_o,
  output logic                         empty_o,
  output logic [$clog2(DEPTH+1)-1:0]   level_o
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int LVL_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [LVL_W-1:0] count_q, count_d;
  logic             do_push, do_pop;

  assign full_o    = (count_q == LVL_W'(DEPTH));
  assign empty_o   = (count_q == '0);
  assign level_o   = count_q;
  assign rd_data_o = mem_q[rd_ptr_q];
  assign do_push   = push_i && !full_o;
  assign do_pop    = pop_i && !empty_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
    end
    if (do_push && !do_pop) begin
      count_d = count_q + LVL_W'(1);
    end else if (do_pop && !do_push) begin
      count_d = count_q - LVL_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= wr_data_i;
    end
  end

endmodule

// ----- src/itoa_front.sv -----
// ---------------------------------------------------------------------------
// itoa_front
// Accepts numbers and classifies them: sign, magnitude and clamped radix.
// ---------------------------------------------------------------------------
module itoa_front (
  input  itoa_pkg::in_item_t in_i,
  input  logic               push_i,
  input  logic               q_full_i,
  output logic               full_o,
  output logic               q_push_o,
  output itoa_pkg::work_t    q_data_o
);

  logic [itoa_pkg::VALUE_BITS-1:0] raw;
  logic                            negative;

  assign raw      = in_i.value;
  assign negative = raw[itoa_pkg::VALUE_BITS-1];

  // The magnitude is unsigned, so the most negative value maps to 2^(N-1).
  always_comb begin
    q_data_o.negative = negative;
    q_data_o.mag      = negative ? ('0 - raw) : raw;
    if (in_i.radix < itoa_pkg::RADIX_MIN) begin
      q_data_o.radix = itoa_pkg::RADIX_MIN;
    end else if (in_i.radix > itoa_pkg::RADIX_MAX) begin
      q_data_o.radix = itoa_pkg::RADIX_MAX;
    end else begin
      q_data_o.radix = in_i.radix;
    end
  end

  assign full_o   = q_full_i;
  assign q_push_o = push_i && !q_full_i;

endmodule

// ----- src/itoa_back.sv -----
// ---------------------------------------------------------------------------
// itoa_back
// Repeated division by the radix into a digit stack, then emission of the
// sign and the digits, most significant first.
// ---------------------------------------------------------------------------
`include "integer_to_ascii_radix_core_defines.svh"

module itoa_back #(
  parameter int RES_DEPTH = itoa_pkg::RES_DEPTH_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  itoa_pkg::work_t                work_i,
  input  logic                           work_empty_i,
  output logic                           work_pop_o,
  input  logic [$clog2(RES_DEPTH+1)-1:0] res_level_i,
  output logic                           res_push_o,
  output itoa_pkg::out_item_t            res_data_o
);

  localparam int LVL_W = $clog2(RES_DEPTH + 1);
  localparam int RB    = itoa_pkg::RADIX_BITS;
  localparam int VB    = itoa_pkg::VALUE_BITS;
  localparam int CB    = itoa_pkg::CNT_BITS;
  localparam int SW    = itoa_pkg::STEP_W;

  itoa_pkg::back_state_e state_q, state_d;

  logic [VB-1:0]  quo_q;
  logic [RB-1:0]  rem_q;
  logic [RB-1:0]  radix_q;
  logic           neg_q;
  logic [SW-1:0]  step_q;
  logic [CB-1:0]  cnt_q;
  logic [CB-1:0]  rd_left_q;
  logic           inflight_q;
  logic           inflight_last_q;
  logic [RB-1:0]  rd_data_q;

  logic [itoa_pkg::DIGIT_BITS-1:0] stack_mem [itoa_pkg::MAX_DIGITS];

  logic [VB-1:0]  div_quo;
  logic [RB-1:0]  div_rem;
  logic [RB:0]    trial;
  logic           step_last;
  logic           quo_zero;
  logic           res_full;
  logic           rd_issue;
  logic [CB-1:0]  rd_next;

  // Restoring division, STEP_BITS quotient bits per cycle. The remainder
  // stays below the radix, so each trial is only one bit wider than it.
  always_comb begin
    div_rem = rem_q;
    div_quo = quo_q;
    trial   = '0;
    for (int b = 0; b < itoa_pkg::STEP_BITS; b++) begin
      trial   = {div_rem, div_quo[VB-1]};
      div_quo = {div_quo[VB-2:0], 1'b0};
      if (trial >= {1'b0, radix_q}) begin
        div_rem    = RB'(trial - {1'b0, radix_q});
        div_quo[0] = 1'b1;
      end else begin
        div_rem = trial[RB-1:0];
      end
    end
  end

  assign step_last = (step_q == SW'(itoa_pkg::DIV_STEPS - 1));
  assign quo_zero  = (div_quo == '0);
  assign res_full  = (res_level_i == LVL_W'(RES_DEPTH));
  assign rd_next   = rd_left_q - CB'(1);

  // A read is issued only when the result queue can take both the character
  // already in flight and the one being read.
  assign rd_issue = (state_q == itoa_pkg::ST_EMIT) && (rd_left_q != '0) &&
                    (((LVL_W+1)'(res_level_i) + (LVL_W+1)'(inflight_q)) <
                     (LVL_W+1)'(RES_DEPTH));

  always_comb begin
    state_d = state_q;
    case (state_q)
      itoa_pkg::ST_IDLE: begin
        if (!work_empty_i) begin
          state_d = itoa_pkg::ST_DIV;
        end
      end
      itoa_pkg::ST_DIV: begin
        if (step_last && quo_zero) begin
          state_d = neg_q ? itoa_pkg::ST_SIGN : itoa_pkg::ST_EMIT;
        end
      end
      itoa_pkg::ST_SIGN: begin
        if (!res_full) begin
          state_d = itoa_pkg::ST_EMIT;
        end
      end
      itoa_pkg::ST_EMIT: begin
        if ((rd_left_q == '0) && !inflight_q) begin
          state_d = itoa_pkg::ST_IDLE;
        end
      end
      default: state_d = itoa_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    work_pop_o           = 1'b0;
    res_push_o           = inflight_q;
    res_data_o.char_code = itoa_pkg::digit_to_char(rd_data_q);
    res_data_o.last_char = inflight_last_q;
    case (state_q)
      itoa_pkg::ST_IDLE: begin
        work_pop_o = !work_empty_i;
      end
      itoa_pkg::ST_SIGN: begin
        res_push_o           = !res_full;
        res_data_o.char_code = itoa_pkg::ASCII_MINUS;
        res_data_o.last_char = 1'b0;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q         <= itoa_pkg::ST_IDLE;
      step_q          <= '0;
      cnt_q           <= '0;
      rd_left_q       <= '0;
      inflight_q      <= 1'b0;
      inflight_last_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      inflight_q <= rd_issue;
      if (rd_issue) begin
        rd_left_q       <= rd_next;
        inflight_last_q <= (rd_next == '0);
      end
      if (work_pop_o) begin
        step_q <= '0;
        cnt_q  <= '0;
      end else if (state_q == itoa_pkg::ST_DIV) begin
        if (step_last) begin
          step_q <= '0;
          cnt_q  <= cnt_q + CB'(1);
          if (quo_zero) begin
            rd_left_q <= cnt_q + CB'(1);
          end
        end else begin
          step_q <= step_q + SW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (work_pop_o) begin
      quo_q   <= work_i.mag;
      rem_q   <= '0;
      radix_q <= work_i.radix;
      neg_q   <= work_i.negative;
    end else if (state_q == itoa_pkg::ST_DIV) begin
      quo_q <= div_quo;
      rem_q <= step_last ? '0 : div_rem;
    end
  end

  // Digit stack: pushed least significant first, read back in reverse.
  always_ff @(posedge clk_i) begin
    if ((state_q == itoa_pkg::ST_DIV) && step_last) begin
      stack_mem[cnt_q[itoa_pkg::DIGIT_AW-1:0]] <= div_rem;
    end
    if (rd_issue) begin
      rd_data_q <= stack_mem[rd_next[itoa_pkg::DIGIT_AW-1:0]];
    end
  end

  `ITOA_ASSERT(a_stack_bound, clk_i, rst_ni,
    (state_q == itoa_pkg::ST_DIV) |-> (cnt_q < CB'(itoa_pkg::MAX_DIGITS)))
  `ITOA_ASSERT(a_rem_below_radix, clk_i, rst_ni,
    (state_q == itoa_pkg::ST_DIV) |-> (rem_q < radix_q))
  `ITOA_NEVER(a_push_into_full, clk_i, rst_ni, res_push_o && res_full)
  `ITOA_ASSERT(a_inflight_in_emit, clk_i, rst_ni,
    inflight_q |-> (state_q == itoa_pkg::ST_EMIT))

endmodule

// ----- src/integer_to_ascii_radix_core.sv -----
// The converter handles one number at a time: it fetches a number from the work queue,
// divides it by the radix (8 quotient bits per cycle) to stack each digit, emits a minus
// sign for a negative number, then replays the digits from the stack. Reset (rst_ni, async,
// active low) empties both queues and idles the converter; the digit stack is not cleared.
// ---------------------------------------------------------------------------
// integer_to_ascii_radix_core
// Converts a signed integer to its ASCII digit string in radix 2 to 36.
// ---------------------------------------------------------------------------
`include "integer_to_ascii_radix_core_defines.svh"

module integer_to_ascii_radix_core #(
  // Numbers that may wait between the front and the converter.
  parameter int WORK_DEPTH = itoa_pkg::WORK_DEPTH_DEF,
  // Characters that may wait on the result side.
  parameter int RES_DEPTH  = itoa_pkg::RES_DEPTH_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push,
  output logic                full,
  input  itoa_pkg::in_item_t  in_i,
  output logic                empty,
  input  logic                pop,
  output itoa_pkg::out_item_t out_o
);

  localparam int WORK_W = $bits(itoa_pkg::work_t);
  localparam int RES_W  = $bits(itoa_pkg::out_item_t);

  // Front side: a number is taken in the cycle push is high and full is low.
  // The front only classifies the number (sign, unsigned magnitude, radix
  // clamped to 2..36) and drops it into the work queue, so input transfers
  // go on while the converter is still busy with an earlier number.
  itoa_pkg::work_t front_work;
  logic            front_push;
  logic            work_full;

  itoa_front u_front (
    .in_i     (in_i),
    .push_i   (push),
    .q_full_i (work_full),
    .full_o   (full),
    .q_push_o (front_push),
    .q_data_o (front_work)
  );

  logic [WORK_W-1:0]                 work_rd_raw;
  itoa_pkg::work_t                   work_head;
  logic                              work_empty;
  logic                              work_pop;
  logic [$clog2(WORK_DEPTH+1)-1:0]   work_level;

  itoa_fifo #(
    .WIDTH (WORK_W),
    .DEPTH (WORK_DEPTH)
  ) u_work_q (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .push_i    (front_push),
    .wr_data_i (front_work),
    .pop_i     (work_pop),
    .rd_data_o (work_rd_raw),
    .full_o    (work_full),
    .empty_o   (work_empty),
    .level_o   (work_level)
  );

  assign work_head = work_rd_raw;

  // Back side: the converter divides the magnitude by the radix over and
  // over, stacking one digit per division, then replays the stack from the
  // top after an optional minus sign. Characters land in the result queue,
  // which decouples the converter from a slow consumer.
  itoa_pkg::out_item_t            back_res;
  logic                           back_push;
  logic [$clog2(RES_DEPTH+1)-1:0] res_level;
  logic [RES_W-1:0]               res_rd_raw;
  logic                           res_full;

  itoa_back #(
    .RES_DEPTH (RES_DEPTH)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .work_i       (work_head),
    .work_empty_i (work_empty),
    .work_pop_o   (work_pop),
    .res_level_i  (res_level),
    .res_push_o   (back_push),
    .res_data_o   (back_res)
  );

  itoa_fifo #(
    .WIDTH (RES_W),
    .DEPTH (RES_DEPTH)
  ) u_res_q (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .push_i    (back_push),
    .wr_data_i (back_res),
    .pop_i     (pop),
    .rd_data_o (res_rd_raw),
    .full_o    (res_full),
    .empty_o   (empty),
    .level_o   (res_level)
  );

  // The oldest waiting character is shown while empty is low.
  assign out_o = res_rd_raw;

  // The work queue level must always agree with its full flag.
  `ITOA_ASSERT(a_work_level, clk_i, rst_ni,
    work_full == (work_level == ($clog2(WORK_DEPTH+1))'(WORK_DEPTH)))
  // A character that is taken must not leave the result queue full next cycle
  // unless the converter refilled it in the same cycle.
  `ITOA_ASSERT(a_res_drain, clk_i, rst_ni,
    (pop && !empty && !back_push) |=> !res_full)
  // The converter only pulls work that the queue actually holds.
  `ITOA_NEVER(a_pop_empty_work, clk_i, rst_ni, work_pop && work_empty)

endmodule

// ----- dv/integer_to_ascii_radix_core_tb.sv -----
// ---------------------------------------------------------------------------
// integer_to_ascii_radix_core_tb
// Self-checking bench for the integer to ASCII radix converter. A directed
// table covers zero, the signed extremes and out-of-range radixes. About
// 450 random numbers follow. Every character that leaves the block is
// compared with a predicted string, with random idling on both sides.
// ---------------------------------------------------------------------------
module integer_to_ascii_radix_core_tb;
  import itoa_pkg::*;

  // Cycles with no transfer on either side before the run is declared hung.
  // The slowest number is a negative one in binary (sign plus 32 digits); the limit
  // leaves a wide margin for it even with idling on the result side.
  localparam int HANG_LIMIT   = 3000;
  // Settling time after the last expected character has been seen.
  localparam int DRAIN_CYCLES = 200;
  localparam int RANDOM_COUNT = 450;

  // One row of the directed plan. An empty text means that the expected
  // characters come from the predictor instead of being typed in.
  typedef struct {
    logic signed [VALUE_BITS-1:0] value;
    logic [RADIX_BITS-1:0]        radix;
    string                        text;
  } number_row_t;

  logic      clk_i  = 1'b0;
  logic      rst_ni = 1'b0;
  logic      push   = 1'b0;
  logic      pop    = 1'b0;
  logic      full;
  logic      empty;
  in_item_t  in_i   = '0;
  out_item_t out_o;

  // Characters still owed by the block, oldest first.
  out_item_t   pending_chars[$];
  number_row_t number_plan[$];

  int  numbers_sent = 0;
  int  chars_seen   = 0;
  int  bad_chars    = 0;
  int  quiet_run    = 0;
  // While set, neither side inserts idle cycles.
  bit  quiet_phase  = 1'b0;

  integer_to_ascii_radix_core dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push   (push),
    .full   (full),
    .in_i   (in_i),
    .empty  (empty),
    .pop    (pop),
    .out_o  (out_o)
  );

  always #5 clk_i = ~clk_i;

  // Appends the character string of one number to the pending queue. The
  // magnitude is taken as unsigned, so the most negative value converts
  // exactly, and the radix is clamped into the range two to thirty-six.
  function automatic void format_number(in_item_t item);
    logic [VALUE_BITS-1:0] mag;
    logic [RADIX_BITS-1:0] base;
    logic [RADIX_BITS-1:0] digit;
    logic [CHAR_BITS-1:0]  code;
    logic [CHAR_BITS-1:0]  digit_codes[$];
    out_item_t             ch;
    bit                    negative;
    negative = item.value[VALUE_BITS-1];
    mag      = negative ? (VALUE_BITS'(0) - item.value) : item.value;
    if (item.radix < RADIX_MIN) begin
      base = RADIX_MIN;
    end else if (item.radix > RADIX_MAX) begin
      base = RADIX_MAX;
    end else begin
      base = item.radix;
    end
    // Digits come out least significant first, so each one goes in front.
    do begin
      digit = RADIX_BITS'(mag % base);
      code  = CHAR_BITS'(digit) + ASCII_ZERO;
      if (digit > LAST_DECIMAL) begin
        code = code + LETTER_GAP;
      end
      digit_codes.push_front(code);
      mag = mag / base;
    end while (mag != 0);
    if (negative) begin
      ch.char_code = ASCII_MINUS;
      ch.last_char = 1'b0;
      pending_chars.push_back(ch);
    end
    foreach (digit_codes[k]) begin
      ch.char_code = digit_codes[k];
      ch.last_char = (k == digit_codes.size() - 1);
      pending_chars.push_back(ch);
    end
  endfunction

  function automatic void add_row(logic signed [VALUE_BITS-1:0] value,
                                  logic [RADIX_BITS-1:0] radix, string text);
    number_row_t row;
    row.value = value;
    row.radix = radix;
    row.text  = text;
    number_plan.push_back(row);
  endfunction

  // Random numbers lean toward the interesting corners: small magnitudes of
  // either sign, the signed extremes and values with random length.
  function automatic logic signed [VALUE_BITS-1:0] pick_value();
    logic [VALUE_BITS-1:0] raw;
    raw = $urandom;
    case ($urandom_range(9))
      0, 1, 2, 3: return raw;
      4:          return $urandom_range(40);
      5:          return -$signed(VALUE_BITS'($urandom_range(1, 40)));
      6: begin
        case ($urandom_range(3))
          0:       return {1'b1, {(VALUE_BITS-1){1'b0}}};
          1:       return {1'b0, {(VALUE_BITS-1){1'b1}}};
          2:       return '0;
          default: return '1;
        endcase
      end
      default:    return raw >> $urandom_range(VALUE_BITS - 1);
    endcase
  endfunction

  // Offers one number to the block and, once the transfer has happened,
  // queues its expected characters: typed text where given, else predicted.
  task automatic send_number(logic signed [VALUE_BITS-1:0] value,
                             logic [RADIX_BITS-1:0] radix, string text);
    in_item_t  item;
    out_item_t ch;
    item.value = value;
    item.radix = radix;
    while (!quiet_phase && $urandom_range(99) < 13) begin
      push <= 1'b0;
      @(posedge clk_i);
    end
    push <= 1'b1;
    in_i <= item;
    @(posedge clk_i);
    while (full) begin
      @(posedge clk_i);
    end
    if (text.len() > 0) begin
      for (int k = 0; k < text.len(); k++) begin
        ch.char_code = CHAR_BITS'(text.getc(k));
        ch.last_char = (k == text.len() - 1);
        pending_chars.push_back(ch);
      end
    end else begin
      format_number(item);
    end
    numbers_sent++;
  endtask

  task automatic report_bad(string what, out_item_t want, out_item_t got);
    bad_chars++;
    if (bad_chars <= 10) begin
      $display("[%0t] %s: expected char 0x%02h last %0b, got char 0x%02h last %0b",
               $realtime, what, want.char_code, want.last_char, got.char_code, got.last_char);
    end
  endtask

  // Result side: checks each character transfer against the oldest pending
  // one, stalls at random, and tracks how long nothing has moved.
  always @(posedge clk_i) begin
    out_item_t want;
    if (rst_ni) begin
      if ((push && !full) || (pop && !empty)) begin
        quiet_run = 0;
      end else begin
        quiet_run++;
      end
      if (pop && !empty) begin
        chars_seen++;
        if (pending_chars.size() == 0) begin
          want = '0;
          report_bad("character with none pending", want, out_o);
        end else begin
          want = pending_chars.pop_front();
          if (out_o.char_code !== want.char_code || out_o.last_char !== want.last_char) begin
            report_bad("character mismatch", want, out_o);
          end
        end
      end
    end
    pop <= quiet_phase || ($urandom_range(99) >= 13);
  end

  // Hang detection: a run that stops moving ends here with a failure.
  initial begin
    while (quiet_run < HANG_LIMIT) begin
      @(posedge clk_i);
    end
    $display("Timed out after %0d cycles without a transfer", HANG_LIMIT);
    $display("integer_to_ascii_radix_core: mismatch");
    $finish;
  end

  initial begin
    logic [RADIX_BITS-1:0] radix;

    // Directed plan. Short strings are typed in; the long binary ones and
    // the mixed cases are left to the predictor.
    add_row(0, 10, "0");
    add_row(0, 2, "0");
    add_row(32'sh8000_0000, 10, "-2147483648");
    add_row(32'sh8000_0000, 16, "-80000000");
    add_row(32'sh8000_0000, 8, "-20000000000");
    add_row(32'sh8000_0000, 2, "");
    add_row(32'sh7fff_ffff, 16, "7fffffff");
    add_row(32'sh7fff_ffff, 36, "zik0zj");
    add_row(32'sh7fff_ffff, 2, "");
    add_row(-1, 2, "-1");
    add_row(-1, 36, "-1");
    add_row(9, 10, "9");
    add_row(100, 10, "100");
    add_row(10, 11, "a");
    add_row(1295, 36, "zz");
    add_row(-255, 16, "-ff");
    // Radixes below two act as binary, those above thirty-six as base 36.
    add_row(5, 0, "101");
    add_row(2, 1, "10");
    add_row(36, 37, "10");
    add_row(35, 63, "z");
    add_row(32'sh1234_5678, 7, "");
    add_row(-123456789, 3, "");
    add_row(32'sh5a5a_5a5a, 32, "");
    add_row(-2147483647, 36, "");
    add_row(-32'sh0765_4321, 45, "");

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (number_plan[k]) begin
      send_number(number_plan[k].value, number_plan[k].radix, number_plan[k].text);
    end

    // Let the block run dry once before the random part starts.
    push <= 1'b0;
    while (pending_chars.size() != 0) begin
      @(posedge clk_i);
    end

    for (int n = 0; n < RANDOM_COUNT; n++) begin
      quiet_phase = (n >= 150 && n < 250);
      if (n == 300) begin
        // Hold the sender off until every pending character has come out.
        push <= 1'b0;
        while (pending_chars.size() != 0) begin
          @(posedge clk_i);
        end
      end
      if ($urandom_range(99) < 15) begin
        radix = RADIX_BITS'($urandom_range(63));
      end else begin
        radix = RADIX_BITS'($urandom_range(36, 2));
      end
      send_number(pick_value(), radix, "");
    end
    quiet_phase = 1'b0;

    push <= 1'b0;
    while (pending_chars.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("Converted %0d numbers into %0d checked characters, %0d wrong.",
             numbers_sent, chars_seen, bad_chars);
    $display("Values spanned both signed extremes and zero; radix codes 0 to 63 were used.");
    if (bad_chars == 0 && pending_chars.size() == 0) begin
      $display("integer_to_ascii_radix_core: match");
    end else begin
      $display("integer_to_ascii_radix_core: mismatch");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
+incdir+src
src/itoa_pkg.sv
src/itoa_fifo.sv
src/itoa_front.sv
src/itoa_back.sv
src/integer_to_ascii_radix_core.sv
dv/integer_to_ascii_radix_core_tb.sv
